/* rtl/uartbt_pkg.sv */
// Shared types and constants for the buffered UART front end.
// Holds ring sizes, operation and result records, and the status and counter codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uartbt_pkg;

	// Ring sizes; each ring keeps one slot free
	localparam int TX_DEPTH = 256;
	localparam int RX_DEPTH = 256;
	localparam int TX_AW    = $clog2(TX_DEPTH);
	localparam int RX_AW    = $clog2(RX_DEPTH);

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	// Input function codes
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_EVENT = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TX_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RX_EMPTY = 2'd2;

	// Counter slots
	localparam int CNT_OVR    = 0;
	localparam int CNT_NOISE  = 1;
	localparam int CNT_FRAME  = 2;
	localparam int CNT_PARITY = 3;
	localparam int CNT_TXDROP = 4;
	localparam int CNT_RXDROP = 5;
	localparam int CNT_NUM    = 6;
	localparam int CNT_W      = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_EVENT = 2'd3
	} op_kind_t;

	// Classified transaction as it travels through the queue
	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] tx_char;
		logic       add_cr;
		logic       rx_ready;
		logic [7:0] rx_byte;
		logic       tx_ready;
		logic       overrun_flag;
		logic       noise_flag;
		logic       frame_flag;
		logic       parity_flag;
	} op_t;

	typedef logic [CNT_NUM-1:0][CNT_W-1:0] cnt_arr_t;

	typedef struct packed {
		logic [1:0] status;
		logic       read_valid;
		logic [7:0] read_char;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       tx_irq_on;
		cnt_arr_t   counts;
	} res_t;

endpackage

`default_nettype wire

/* rtl/uartbt_front.sv */
// Front end: accepts input transactions, holds the newline option register,
// and classifies each transaction into an operation record. Uses uartbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uartbt_front import uartbt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	input  wire logic [7:0] tx_char,
	input  wire logic       rx_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       tx_ready,
	input  wire logic       overrun_flag,
	input  wire logic       noise_flag,
	input  wire logic       frame_flag,
	input  wire logic       parity_flag,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	output logic            q_push,
	output op_t             q_op,
	input  wire logic       q_full
);

	logic cr_after_newline_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_after_newline_q <= 1'b1;
		end else if (cfg_valid) begin
			cr_after_newline_q <= cfg_data;
		end
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_op              = '0;
		q_op.tx_char      = tx_char;
		q_op.rx_ready     = rx_ready;
		q_op.rx_byte      = rx_byte;
		q_op.tx_ready     = tx_ready;
		q_op.overrun_flag = overrun_flag;
		q_op.noise_flag   = noise_flag;
		q_op.frame_flag   = frame_flag;
		q_op.parity_flag  = parity_flag;
		// Decide the carriage return now so later option writes cannot race it
		q_op.add_cr       = (tx_char == CHAR_NL) && cr_after_newline_q;
		case (func)
			FUNC_WRITE: q_op.kind = OP_WRITE;
			FUNC_READ:  q_op.kind = OP_READ;
			FUNC_EVENT: q_op.kind = OP_EVENT;
			default:    q_op.kind = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/uartbt_queue.sv */
// Short operation queue between the front end and the back end.
// Stores op_t records from uartbt_pkg in a small register file.
`timescale 1ns / 1ps
`default_nettype none

module uartbt_queue import uartbt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output op_t       pop_op,
	output logic      empty
);

	op_t              slot_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;

	function automatic logic [Q_AW-1:0] q_next(input logic [Q_AW-1:0] i);
		if (i == Q_AW'(Q_DEPTH - 1)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	assign full   = (count_q == Q_CW'(Q_DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= q_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= q_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

/* rtl/uartbt_back.sv */
// Back end: sequencer that carries out queued operations on the transmit and
// receive rings, the interrupt enable and the counters. Uses uartbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uartbt_back import uartbt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire op_t  op,
	input  wire logic op_valid,
	output logic      op_pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CR   = 3'b010,
		ST_RD   = 3'b100
	} st_t;

	st_t              state_q, state_d;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q;
	logic [RX_AW-1:0] rx_head_q, rx_tail_q;
	logic             irq_q, irq_d;
	cnt_arr_t         cnt_q, cnt_d;
	logic [1:0]       status_q, status_d;
	logic             pend_read_q, pend_read_d;
	logic             pend_send_q, pend_send_d;
	logic             out_valid_q;
	res_t             res_q;

	logic [7:0] tx_mem [TX_DEPTH];
	logic [7:0] rx_mem [RX_DEPTH];
	logic [7:0] tx_rd_q, rx_rd_q;

	logic               slot_free, produce;
	logic               tx_full, tx_empty, rx_full, rx_empty;
	logic               tx_wr_try, tx_we, tx_re, rx_we, rx_re, irq_clr;
	logic [7:0]         tx_wr_byte;
	logic [CNT_NUM-1:0] bump;

	function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] i);
		if (i == TX_AW'(TX_DEPTH - 1)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] i);
		if (i == RX_AW'(RX_DEPTH - 1)) begin
			return '0;
		end
		return i + 1'b1;
	endfunction

	assign tx_full   = (tx_next(tx_head_q) == tx_tail_q);
	assign tx_empty  = (tx_head_q == tx_tail_q);
	assign rx_full   = (rx_next(rx_head_q) == rx_tail_q);
	assign rx_empty  = (rx_head_q == rx_tail_q);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d     = state_q;
		produce     = 1'b0;
		op_pop      = 1'b0;
		status_d    = status_q;
		pend_read_d = pend_read_q;
		pend_send_d = pend_send_q;
		tx_wr_try   = 1'b0;
		tx_wr_byte  = op.tx_char;
		tx_re       = 1'b0;
		rx_we       = 1'b0;
		rx_re       = 1'b0;
		irq_clr     = 1'b0;
		bump        = '0;
		case (state_q)
			ST_IDLE: begin
				if (op_valid && slot_free) begin
					op_pop      = 1'b1;
					pend_read_d = 1'b0;
					pend_send_d = 1'b0;
					status_d    = STATUS_OK;
					case (op.kind)
						OP_WRITE: begin
							tx_wr_try = 1'b1;
							if (tx_full) begin
								status_d = STATUS_TX_FULL;
							end
							if (op.add_cr) begin
								state_d = ST_CR;
							end else begin
								produce = 1'b1;
							end
						end
						OP_READ: begin
							if (rx_empty) begin
								status_d = STATUS_RX_EMPTY;
								produce  = 1'b1;
							end else begin
								rx_re       = 1'b1;
								pend_read_d = 1'b1;
								state_d     = ST_RD;
							end
						end
						OP_EVENT: begin
							if (op.rx_ready) begin
								if (rx_full) begin
									bump[CNT_RXDROP] = 1'b1;
								end else begin
									rx_we = 1'b1;
								end
							end
							if (op.tx_ready && tx_empty) begin
								irq_clr = 1'b1;
							end
							bump[CNT_OVR]    = op.overrun_flag;
							bump[CNT_NOISE]  = op.noise_flag;
							bump[CNT_FRAME]  = op.frame_flag;
							bump[CNT_PARITY] = op.parity_flag;
							if (op.tx_ready && !tx_empty) begin
								tx_re       = 1'b1;
								pend_send_d = 1'b1;
								state_d     = ST_RD;
							end else begin
								produce = 1'b1;
							end
						end
						default: begin
							produce = 1'b1;
						end
					endcase
				end
			end
			ST_CR: begin
				// Second ring write of a newline; head already moved past it unless it was dropped
				tx_wr_try  = 1'b1;
				tx_wr_byte = CHAR_CR;
				if (tx_full) begin
					status_d = STATUS_TX_FULL;
				end
				produce = 1'b1;
				state_d = ST_IDLE;
			end
			ST_RD: begin
				produce = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		tx_we = tx_wr_try && !tx_full;
		if (tx_wr_try && tx_full) begin
			bump[CNT_TXDROP] = 1'b1;
		end
	end

	always_comb begin
		irq_d = irq_q;
		if (tx_we) begin
			irq_d = 1'b1;
		end else if (irq_clr) begin
			irq_d = 1'b0;
		end
		for (int k = 0; k < CNT_NUM; k++) begin
			cnt_d[k] = (bump[k] && cnt_q[k] != CNT_MAX) ? cnt_q[k] + 1'b1 : cnt_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			irq_q       <= 1'b0;
			cnt_q       <= '0;
			status_q    <= STATUS_OK;
			pend_read_q <= 1'b0;
			pend_send_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			irq_q       <= irq_d;
			cnt_q       <= cnt_d;
			status_q    <= status_d;
			pend_read_q <= pend_read_d;
			pend_send_q <= pend_send_d;
			if (tx_we) begin
				tx_head_q <= tx_next(tx_head_q);
			end
			if (tx_re) begin
				tx_tail_q <= tx_next(tx_tail_q);
			end
			if (rx_we) begin
				rx_head_q <= rx_next(rx_head_q);
			end
			if (rx_re) begin
				rx_tail_q <= rx_next(rx_tail_q);
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_head_q] <= tx_wr_byte;
		end
		if (tx_re) begin
			tx_rd_q <= tx_mem[tx_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_head_q] <= op.rx_byte;
		end
		if (rx_re) begin
			rx_rd_q <= rx_mem[rx_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			res_q.status     <= status_d;
			res_q.read_valid <= (state_q == ST_RD) && pend_read_q;
			res_q.read_char  <= ((state_q == ST_RD) && pend_read_q) ? rx_rd_q : 8'h00;
			res_q.send_valid <= (state_q == ST_RD) && pend_send_q;
			res_q.send_byte  <= ((state_q == ST_RD) && pend_send_q) ? tx_rd_q : 8'h00;
			res_q.tx_irq_on  <= irq_d;
			res_q.counts     <= cnt_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		produce |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

	a_rd_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> $past(op_pop))
		else $error("memory read state entered without a popped operation");

	a_second_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CR || state_q == ST_RD) |-> produce)
		else $error("second step of an operation produced no result");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(tx_head_q) < TX_DEPTH) && (32'(tx_tail_q) < TX_DEPTH)
		&& (32'(rx_head_q) < RX_DEPTH) && (32'(rx_tail_q) < RX_DEPTH))
		else $error("ring pointer out of range");

endmodule

`default_nettype wire

/* rtl/uart_buffered_tty.sv */
// Buffered UART front end: transmit ring and receive ring between software and one UART.
// Each result is registered; a newline with carriage return (second ring write), a successful
// read, or an event that sends a byte (one registered ring read) takes a second sequencer step.
// The sequencer pops no new transaction until the last is done and the result slot is free.
// Reset (arst_n, async): pointers, counters, interrupt enable and queue cleared, newline
// option set; ring contents are not cleared and hold nothing until written.
`timescale 1ns / 1ps
`default_nettype none

module uart_buffered_tty import uartbt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input transactions
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  tx_char,
	input  wire logic        rx_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        tx_ready,
	input  wire logic        overrun_flag,
	input  wire logic        noise_flag,
	input  wire logic        frame_flag,
	input  wire logic        parity_flag,
	// Result transactions
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             read_valid,
	output logic [7:0]       read_char,
	output logic             send_valid,
	output logic [7:0]       send_byte,
	output logic             tx_irq_on,
	output logic [15:0]      count_uart_overrun,
	output logic [15:0]      count_noise,
	output logic [15:0]      count_frame,
	output logic [15:0]      count_parity,
	output logic [15:0]      count_tx_drop,
	output logic [15:0]      count_rx_drop,
	// Newline option register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);

	op_t  push_op, pop_op;
	logic q_push, q_full, q_empty, q_pop;
	res_t res;

	// Classify each input transaction and hold the newline option
	uartbt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.tx_char      (tx_char),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.tx_ready     (tx_ready),
		.overrun_flag (overrun_flag),
		.noise_flag   (noise_flag),
		.frame_flag   (frame_flag),
		.parity_flag  (parity_flag),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.q_push       (q_push),
		.q_op         (push_op),
		.q_full       (q_full)
	);

	// Decouple acceptance from execution so either side can stall alone
	uartbt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (q_pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	// Execute operations on the rings and counters, hold the result register
	uartbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (pop_op),
		.op_valid  (!q_empty),
		.op_pop    (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// Split the result record onto the ports
	assign status             = res.status;
	assign read_valid         = res.read_valid;
	assign read_char          = res.read_char;
	assign send_valid         = res.send_valid;
	assign send_byte          = res.send_byte;
	assign tx_irq_on          = res.tx_irq_on;
	assign count_uart_overrun = res.counts[CNT_OVR];
	assign count_noise        = res.counts[CNT_NOISE];
	assign count_frame        = res.counts[CNT_FRAME];
	assign count_parity       = res.counts[CNT_PARITY];
	assign count_tx_drop      = res.counts[CNT_TXDROP];
	assign count_rx_drop      = res.counts[CNT_RXDROP];

endmodule

`default_nettype wire

/* tb/sv/tb_uart_buffered_tty.sv */
// Self-checking testbench for uart_buffered_tty: directed, random and backpressure traffic.
// Predicts every result from its own copy of both rings, the counters and the newline option.
// Depends on uartbt_pkg and the uart_buffered_tty RTL only.
`timescale 1ns / 1ps

module tb_uart_buffered_tty;
	import uartbt_pkg::*;

	// func value the block must ignore (no name for it in the package)
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam int          RESET_CYCLES  = 2;
	localparam int unsigned CYCLE_LIMIT   = 100_000;
	localparam int          PRESSURE_HOLD = 300;
	localparam int          DRAIN_TAIL    = 10;
	localparam int          IDLE_PERCENT  = 14;

	// One input transaction; errs is {overrun, noise, frame, parity}
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] tx_char;
		logic       rx_ready;
		logic [7:0] rx_byte;
		logic       tx_ready;
		logic [3:0] errs;
	} tty_item_t;

	// Traffic mixes for the random part
	typedef enum int {
		MIX_BALANCED = 0,
		MIX_FILL_TX  = 1,
		MIX_FILL_RX  = 2,
		MIX_DRAIN    = 3
	} mix_t;

	// DUT ports; all inputs known from time zero
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  func         = FUNC_WRITE;
	logic [7:0]  tx_char      = 8'h00;
	logic        rx_ready     = 1'b0;
	logic [7:0]  rx_byte      = 8'h00;
	logic        tx_ready     = 1'b0;
	logic        overrun_flag = 1'b0;
	logic        noise_flag   = 1'b0;
	logic        frame_flag   = 1'b0;
	logic        parity_flag  = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [1:0]  status;
	logic        read_valid;
	logic [7:0]  read_char;
	logic        send_valid;
	logic [7:0]  send_byte;
	logic        tx_irq_on;
	logic [15:0] count_uart_overrun;
	logic [15:0] count_noise;
	logic [15:0] count_frame;
	logic [15:0] count_parity;
	logic [15:0] count_tx_drop;
	logic [15:0] count_rx_drop;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic        cfg_data     = 1'b0;

	// Predicted block state, as it is right after reset
	logic [7:0]   tx_ring [TX_DEPTH];
	logic [7:0]   rx_ring [RX_DEPTH];
	int unsigned  tx_put, tx_take, rx_put, rx_take;
	bit           tx_irq_en;
	logic [15:0]  err_count [CNT_NUM] = '{default: 16'd0};
	bit           cr_option = 1'b1;

	// Expected results, oldest first
	res_t pending_tty_results [$];

	// Bookkeeping
	int unsigned cycle_count;
	int          mismatch_count;
	int          accepted_count;
	int          results_checked;
	int          input_stall_cycles;
	int          tx_full_hits;
	int          rx_full_hits;
	bit          idle_enable = 1'b1;
	int          hold_requests;
	int          hold_served;
	int          hold_left;

	uart_buffered_tty dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.func               (func),
		.tx_char            (tx_char),
		.rx_ready           (rx_ready),
		.rx_byte            (rx_byte),
		.tx_ready           (tx_ready),
		.overrun_flag       (overrun_flag),
		.noise_flag         (noise_flag),
		.frame_flag         (frame_flag),
		.parity_flag        (parity_flag),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.read_valid         (read_valid),
		.read_char          (read_char),
		.send_valid         (send_valid),
		.send_byte          (send_byte),
		.tx_irq_on          (tx_irq_on),
		.count_uart_overrun (count_uart_overrun),
		.count_noise        (count_noise),
		.count_frame        (count_frame),
		.count_parity       (count_parity),
		.count_tx_drop      (count_tx_drop),
		.count_rx_drop      (count_rx_drop),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	// Saturate at the top of the 16-bit range
	function automatic void bump_count(input int slot);
		if (err_count[slot] != CNT_MAX)
			err_count[slot] = err_count[slot] + 16'd1;
	endfunction

	// Queue one byte on the transmit ring; drop and count it when only the spare slot is left
	function automatic bit push_tx(input logic [7:0] c);
		int unsigned nxt;
		nxt = (tx_put + 1) % TX_DEPTH;
		if (nxt == tx_take) begin
			bump_count(CNT_TXDROP);
			tx_full_hits++;
			return 1'b0;
		end
		tx_ring[tx_put] = c;
		tx_put = nxt;
		tx_irq_en = 1'b1;
		return 1'b1;
	endfunction

	// Advance the predicted state by one transaction and return the result it must produce
	function automatic res_t next_tty_result(input tty_item_t it);
		res_t r;
		int unsigned nxt;
		int k;
		r = '0;
		case (it.func)
			FUNC_WRITE: begin
				if (!push_tx(it.tx_char))
					r.status = STATUS_TX_FULL;
				// The carriage return is tried even when the newline was dropped
				if (it.tx_char == CHAR_NL && cr_option) begin
					if (!push_tx(CHAR_CR))
						r.status = STATUS_TX_FULL;
				end
			end
			FUNC_READ: begin
				if (rx_take == rx_put) begin
					r.status = STATUS_RX_EMPTY;
				end else begin
					r.read_valid = 1'b1;
					r.read_char  = rx_ring[rx_take];
					rx_take      = (rx_take + 1) % RX_DEPTH;
				end
			end
			FUNC_EVENT: begin
				// Receive side first, then transmit side, then line errors; status stays ok
				if (it.rx_ready) begin
					nxt = (rx_put + 1) % RX_DEPTH;
					if (nxt == rx_take) begin
						bump_count(CNT_RXDROP);
						rx_full_hits++;
					end else begin
						rx_ring[rx_put] = it.rx_byte;
						rx_put = nxt;
					end
				end
				if (it.tx_ready) begin
					if (tx_take == tx_put) begin
						tx_irq_en = 1'b0;
					end else begin
						r.send_valid = 1'b1;
						r.send_byte  = tx_ring[tx_take];
						tx_take      = (tx_take + 1) % TX_DEPTH;
					end
				end
				if (it.errs[3]) bump_count(CNT_OVR);
				if (it.errs[2]) bump_count(CNT_NOISE);
				if (it.errs[1]) bump_count(CNT_FRAME);
				if (it.errs[0]) bump_count(CNT_PARITY);
			end
			default: begin
				// Unused func code: no state change
			end
		endcase
		r.tx_irq_on = tx_irq_en;
		for (k = 0; k < CNT_NUM; k++)
			r.counts[k] = err_count[k];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch at result %0d: %s", $time, results_checked, what);
	endtask

	// Compare the result on the output port with the oldest expectation, field by field
	task automatic check_tty_result();
		res_t want;
		logic [15:0] got_counts [CNT_NUM];
		int k;
		if (pending_tty_results.size() == 0) begin
			flag_mismatch("result with no transaction waiting for it");
			return;
		end
		want = pending_tty_results.pop_front();
		results_checked++;
		got_counts[CNT_OVR]    = count_uart_overrun;
		got_counts[CNT_NOISE]  = count_noise;
		got_counts[CNT_FRAME]  = count_frame;
		got_counts[CNT_PARITY] = count_parity;
		got_counts[CNT_TXDROP] = count_tx_drop;
		got_counts[CNT_RXDROP] = count_rx_drop;
		if (status !== want.status)
			flag_mismatch($sformatf("status %0h, want %0h", status, want.status));
		if (read_valid !== want.read_valid)
			flag_mismatch($sformatf("read_valid %0h, want %0h", read_valid, want.read_valid));
		if (read_char !== want.read_char)
			flag_mismatch($sformatf("read_char %0h, want %0h", read_char, want.read_char));
		if (send_valid !== want.send_valid)
			flag_mismatch($sformatf("send_valid %0h, want %0h", send_valid, want.send_valid));
		if (send_byte !== want.send_byte)
			flag_mismatch($sformatf("send_byte %0h, want %0h", send_byte, want.send_byte));
		if (tx_irq_on !== want.tx_irq_on)
			flag_mismatch($sformatf("tx_irq_on %0h, want %0h", tx_irq_on, want.tx_irq_on));
		for (k = 0; k < CNT_NUM; k++) begin
			if (got_counts[k] !== want.counts[k])
				flag_mismatch($sformatf("counter slot %0d is %0h, want %0h",
					k, got_counts[k], want.counts[k]));
		end
	endtask

	// Sample every handshake at the rising edge; ports hold their pre-edge values here.
	// Push the expectation before checking so a same-edge result still finds it.
	always @(posedge clk) begin : watch_ports
		tty_item_t seen;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cr_option = cfg_data;
			if (in_valid && in_ready) begin
				seen.func     = func;
				seen.tx_char  = tx_char;
				seen.rx_ready = rx_ready;
				seen.rx_byte  = rx_byte;
				seen.tx_ready = tx_ready;
				seen.errs     = {overrun_flag, noise_flag, frame_flag, parity_flag};
				accepted_count++;
				pending_tty_results.push_back(next_tty_result(seen));
			end
			if (in_valid && !in_ready)
				input_stall_cycles++;
			if (out_valid && out_ready)
				check_tty_result();
		end
	end

	// Receiver: stall at random, or hold off for a long stretch when a test asks for it
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = PRESSURE_HOLD;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[%0t] run stopped after %0d cycles with %0d results outstanding",
				$time, cycle_count, pending_tty_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic tty_item_t tty_txn(input logic [1:0] f, input logic [7:0] tc,
			input logic rr, input logic [7:0] rb, input logic tr, input logic [3:0] errs);
		tty_item_t it;
		it.func     = f;
		it.tx_char  = tc;
		it.rx_ready = rr;
		it.rx_byte  = rb;
		it.tx_ready = tr;
		it.errs     = errs;
		return it;
	endfunction

	// Random transaction; the mix steers the rings toward full, empty or a balance
	function automatic tty_item_t random_item(input mix_t mix);
		tty_item_t it;
		int pick;
		int b;
		it.tx_char  = ($urandom_range(9) == 0) ? CHAR_NL : 8'($urandom_range(255));
		it.rx_ready = 1'($urandom_range(1));
		it.rx_byte  = 8'($urandom_range(255));
		it.tx_ready = 1'($urandom_range(1));
		for (b = 0; b < 4; b++)
			it.errs[b] = ($urandom_range(3) == 0);
		pick = $urandom_range(99);
		if (pick < 2) begin
			it.func = FUNC_UNUSED;
			return it;
		end
		case (mix)
			MIX_FILL_TX: begin
				it.func = (pick < 75) ? FUNC_WRITE : (pick < 92) ? FUNC_EVENT : FUNC_READ;
				it.tx_ready = ($urandom_range(3) == 0);
			end
			MIX_FILL_RX: begin
				it.func = (pick < 75) ? FUNC_EVENT : (pick < 85) ? FUNC_READ : FUNC_WRITE;
				it.rx_ready = ($urandom_range(7) != 0);
			end
			MIX_DRAIN: begin
				it.func = (pick < 45) ? FUNC_READ : (pick < 95) ? FUNC_EVENT : FUNC_WRITE;
				it.tx_ready = 1'b1;
				it.rx_ready = ($urandom_range(7) == 0);
			end
			default: begin
				it.func = (pick < 32) ? FUNC_WRITE : (pick < 57) ? FUNC_READ : FUNC_EVENT;
			end
		endcase
		return it;
	endfunction

	// Offer one transaction and hold it until accepted; idle first at random
	task automatic send_item(input tty_item_t it);
		if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= it.func;
		tx_char      <= it.tx_char;
		rx_ready     <= it.rx_ready;
		rx_byte      <= it.rx_byte;
		tx_ready     <= it.tx_ready;
		overrun_flag <= it.errs[3];
		noise_flag   <= it.errs[2];
		frame_flag   <= it.errs[1];
		parity_flag  <= it.errs[0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid and wait for every outstanding result; the first edge lets the
	// last accepted transaction reach the expectation queue
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tty_results.size() != 0) @(posedge clk);
	endtask

	// Write the newline option only once the block is idle
	task automatic program_newline_option(input bit cr);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= cr;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Every operation on small rings: empty read, interrupt off on empty ring, ignored code,
	// newline plus carriage return, byte extremes, sends, reads and all line errors
	task automatic test_basic_operations();
		program_newline_option(1'b1);
		send_item(tty_txn(FUNC_READ,   8'h00, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_EVENT,  8'h00, 1'b0, 8'h00, 1'b1, 4'b0000));
		send_item(tty_txn(FUNC_UNUSED, 8'hFF, 1'b1, 8'hFF, 1'b1, 4'b1111));
		send_item(tty_txn(FUNC_WRITE,  8'h41, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_WRITE,  CHAR_NL, 1'b1, 8'hFF, 1'b1, 4'b1111));
		send_item(tty_txn(FUNC_WRITE,  8'h00, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_WRITE,  8'hFF, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_EVENT,  8'h00, 1'b1, 8'h00, 1'b1, 4'b0000));
		send_item(tty_txn(FUNC_EVENT,  8'hFF, 1'b1, 8'hFF, 1'b1, 4'b1111));
		send_item(tty_txn(FUNC_EVENT,  8'h00, 1'b0, 8'h55, 1'b1, 4'b1000));
		send_item(tty_txn(FUNC_READ,   8'hFF, 1'b1, 8'hFF, 1'b1, 4'b1111));
		send_item(tty_txn(FUNC_READ,   8'h00, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_READ,   8'h00, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_EVENT,  8'h00, 1'b0, 8'h00, 1'b1, 4'b0100));
		send_item(tty_txn(FUNC_EVENT,  8'h00, 1'b0, 8'h00, 1'b1, 4'b0010));
		send_item(tty_txn(FUNC_EVENT,  8'h00, 1'b0, 8'h00, 1'b1, 4'b0001));
		send_item(tty_txn(FUNC_UNUSED, 8'h00, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_EVENT,  8'h00, 1'b0, 8'h00, 1'b0, 4'b0101));
	endtask

	// With the option off a newline goes out alone; a plain carriage return is just a byte
	task automatic test_newline_option();
		program_newline_option(1'b0);
		send_item(tty_txn(FUNC_WRITE, CHAR_NL, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_WRITE, CHAR_CR, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 4'b0000));
		send_item(tty_txn(FUNC_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 4'b0000));
		send_item(tty_txn(FUNC_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 4'b0000));
	endtask

	// Fill the transmit ring to one spare slot, then hit the newline edge cases:
	// newline fits but its carriage return is dropped, then both are dropped
	task automatic test_tx_ring_overflow();
		logic [7:0] c;
		int i;
		program_newline_option(1'b1);
		for (i = 0; i < TX_DEPTH - 2; i++) begin
			c = 8'($urandom_range(255));
			if (c == CHAR_NL)
				c = 8'h00;
			send_item(tty_txn(FUNC_WRITE, c, 1'b0, 8'h00, 1'b0, 4'b0000));
		end
		send_item(tty_txn(FUNC_WRITE, CHAR_NL, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_WRITE, CHAR_NL, 1'b0, 8'h00, 1'b0, 4'b0000));
		send_item(tty_txn(FUNC_WRITE, CHAR_CR, 1'b0, 8'h00, 1'b0, 4'b0000));
		// Drain all of it in order, then once more on the empty ring
		for (i = 0; i < TX_DEPTH; i++)
			send_item(tty_txn(FUNC_EVENT, 8'h00, 1'b0, 8'h00, 1'b1, 4'b0000));
	endtask

	// Fill the receive ring, overflow it (status must stay ok), then read it all back
	task automatic test_rx_ring_overflow();
		int i;
		for (i = 0; i < RX_DEPTH + 2; i++)
			send_item(tty_txn(FUNC_EVENT, 8'h00, 1'b1, 8'($urandom_range(255)), 1'b0, 4'b0000));
		for (i = 0; i < RX_DEPTH; i++)
			send_item(tty_txn(FUNC_READ, 8'h00, 1'b0, 8'h00, 1'b0, 4'b0000));
	endtask

	// Hold off the receiver while the sender keeps offering, so the block stalls its input
	task automatic test_output_backpressure();
		int i;
		drain_results();
		hold_requests++;
		for (i = 0; i < 60; i++)
			send_item(random_item(MIX_BALANCED));
	endtask

	// Random bursts, each with its own mix and length
	task automatic test_random_traffic(input int n_items, input bit cr, input bit idle);
		mix_t mix;
		int burst_left;
		int i;
		program_newline_option(cr);
		idle_enable = idle;
		burst_left  = 0;
		mix         = MIX_BALANCED;
		for (i = 0; i < n_items; i++) begin
			if (burst_left == 0) begin
				mix        = mix_t'($urandom_range(3));
				burst_left = $urandom_range(20, 200);
			end
			burst_left--;
			send_item(random_item(mix));
		end
		drain_results();
		idle_enable = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_operations();
		test_newline_option();
		test_tx_ring_overflow();
		test_rx_ring_overflow();
		test_output_backpressure();
		test_random_traffic(110, 1'b0, 1'b1);
		test_random_traffic(110, 1'b1, 1'b1);
		test_random_traffic(110, 1'b0, 1'b0);
		test_random_traffic(110, 1'b1, 1'b1);

		// Let any stray result show up, then account for leftovers
		drain_results();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (pending_tty_results.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived",
				pending_tty_results.size()));

		$display("Covered %0d transactions and %0d results; %0d bytes lost on a full transmit",
			accepted_count, results_checked, tx_full_hits);
		$display("ring, %0d on a full receive ring; input held back %0d cycles.",
			rx_full_hits, input_stall_cycles);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/uartbt_pkg.sv
rtl/uartbt_front.sv
rtl/uartbt_queue.sv
rtl/uartbt_back.sv
rtl/uart_buffered_tty.sv
tb/sv/tb_uart_buffered_tty.sv
